>>> src/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg: shared types and constants for the frequency combination search
// Field widths, register reset values, result codes and sequencer states.
// ----------------------------------------------------------------------------
package fcs_pkg;

  // Field widths
  localparam int FREQ_W     = 31;  // stored frequency, 1/1024 microHz
  localparam int FIELD_IDX_W = 6;  // index fields on the stream
  localparam int REG_W      = 20;  // tolerance and alias spacing
  localparam int RES_W      = 21;  // signed residual
  localparam int ALU_W      = 35;  // signed width of the shared adder
  localparam int SPAN_W     = 7;   // holds INDEX_SPAN itself
  localparam int INDEX_SPAN = 64;  // results never run past index 63

  // Stream packing
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 80;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_TOLERANCE = 1'b0;  // byte address 0
  localparam logic REG_ALIAS     = 1'b1;  // byte address 4

  localparam logic [REG_W-1:0] TOLERANCE_RESET = 20'd410;    // 0.4 microHz
  localparam logic [REG_W-1:0] ALIAS_RESET     = 20'd11848;  // 11.57 microHz

  // Item kinds
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Match codes
  typedef logic [1:0] code_t;
  localparam code_t CODE_NONE  = 2'd0;
  localparam code_t CODE_EXACT = 2'd1;
  localparam code_t CODE_MINUS = 2'd2;
  localparam code_t CODE_PLUS  = 2'd3;

  // Which sum is under test
  typedef enum logic [1:0] {
    T_SUM,        // A + B
    T_DBL_FIRST,  // 2A + B
    T_DBL_SECOND  // A + 2B
  } test_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_A,
    S_LD_C,
    S_LD_2,
    S_LD_B,
    S_DIFF,
    S_CAND,
    S_OUT
  } state_t;

endpackage

>>> src/frequency_combination_search.sv
// ----------------------------------------------------------------------------
// frequency_combination_search
// Keeps a list of frequencies and, per search beat, tests A+B, 2A+B and A+2B
// against a target C for every B from A's index upward, one result beat each.
// ----------------------------------------------------------------------------
//
//  channel  | direction | signals                                | beat
//  ---------+-----------+----------------------------------------+----------------------
//  s_*      | in        | s_tvalid s_tready s_tdata s_tuser      | append or search
//  m_*      | out       | m_tvalid m_tready m_tdata m_tuser m_tlast | one result
//  APB      | in/out    | psel penable pwrite paddr pwdata prdata pready | tolerance, alias
//
//  An append beat is written while the block stays idle. A search beat steps
//  through the accept, the reads of A and C and forming A-C and 2A-C, while
//  the first B is read. Each result then takes, for each of the three sums,
//  one add plus one to three tolerance checks through the single shared adder,
//  then the result beat; every later result adds a step to read its B.
//  A bad index goes straight to its one result beat.
//  s_tready is low from a search beat until its last result beat is taken;
//  a stalled result holds the sequencer. Reset empties the list and loads the
//  register defaults; the frequency memory itself is not cleared.
//
module frequency_combination_search #(
  parameter int MAX_FREQS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // freq_value[30:0], target_index[36:31], first_index[42:37], zero fill
  input  logic [fcs_pkg::S_TDATA_W-1:0]     s_tdata,
  // op[0], restart_list[1]
  input  logic [fcs_pkg::S_TUSER_W-1:0]     s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // second_index[5:0], sum_code[7:6], sum_residual[28:8],
  // double_first_code[30:29], double_first_residual[51:31],
  // double_second_code[53:52], double_second_residual[74:54], zero fill
  output logic [fcs_pkg::M_TDATA_W-1:0]     m_tdata,
  // bad_index[0]
  output logic                              m_tuser,
  output logic                              m_tlast,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fcs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fcs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fcs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import fcs_pkg::*;

  localparam int IDX_W = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1;
  localparam int CNT_W = $clog2(MAX_FREQS + 1);
  localparam int CMP_W = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;

  // Configuration registers
  logic [REG_W-1:0] match_tolerance;
  logic [REG_W-1:0] alias_spacing;

  // List storage
  logic [FREQ_W-1:0] freq_mem [MAX_FREQS];
  logic [FREQ_W-1:0] mem_rdata;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  logic [CNT_W-1:0]  stored_count;

  // Sequencer
  state_t state;
  state_t state_next;
  test_t  test;
  code_t  try_code;

  // Search operands
  logic [FIELD_IDX_W-1:0]   k_reg;
  logic [SPAN_W-1:0]        j_cnt;
  logic [FREQ_W-1:0]        a_val;
  logic [FREQ_W-1:0]        b_val;
  logic signed [ALU_W-1:0]  amc;   // A - C
  logic signed [ALU_W-1:0]  a2mc;  // 2A - C
  logic signed [ALU_W-1:0]  d_val;

  // Result registers
  logic                     bad_flag;
  code_t                    sum_code;
  code_t                    dfirst_code;
  code_t                    dsecond_code;
  logic [RES_W-1:0]         sum_res;
  logic [RES_W-1:0]         dfirst_res;
  logic [RES_W-1:0]         dsecond_res;

  // Stream fields
  logic                     in_op;
  logic                     in_restart;
  logic [FREQ_W-1:0]        in_freq;
  logic [FIELD_IDX_W-1:0]   in_target;
  logic [FIELD_IDX_W-1:0]   in_first;
  logic                     in_accept;
  logic                     out_accept;

  // Shared adder
  logic signed [ALU_W-1:0]  alu_x;
  logic signed [ALU_W-1:0]  alu_y;
  logic                     alu_sub;
  logic signed [ALU_W-1:0]  alu_sum;
  logic signed [ALU_W-1:0]  tol_s;
  logic                     cand_match;
  logic                     test_done;
  code_t                    hit_code;
  logic [RES_W-1:0]         hit_res;
  code_t                    try_code_next;

  // Bounds
  logic [CMP_W-1:0]         cnt_ext;
  logic [CMP_W-1:0]         end_ext;
  logic                     in_bad;
  logic                     last_result;

  assign in_freq    = s_tdata[30:0];
  assign in_target  = s_tdata[36:31];
  assign in_first   = s_tdata[42:37];
  assign in_op      = s_tuser[0];
  assign in_restart = s_tuser[1];

  assign in_accept  = s_tvalid & s_tready;
  assign out_accept = m_tvalid & m_tready;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= TOLERANCE_RESET;
      alias_spacing   <= ALIAS_RESET;
    end else if (psel & penable & pwrite & pready) begin
      if (paddr[2] == REG_TOLERANCE) begin
        match_tolerance <= pwdata[REG_W-1:0];
      end else begin
        alias_spacing <= pwdata[REG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ALIAS) ? APB_DATA_W'(alias_spacing)
                                          : APB_DATA_W'(match_tolerance);

  // ---------------------------------------------------------------------------
  // List bounds
  // ---------------------------------------------------------------------------
  assign cnt_ext = CMP_W'(stored_count);
  assign end_ext = (cnt_ext >= CMP_W'(INDEX_SPAN)) ? CMP_W'(INDEX_SPAN) : cnt_ext;
  assign in_bad  = (CMP_W'(in_target) >= cnt_ext) | (CMP_W'(in_first) >= cnt_ext);
  assign last_result = bad_flag | ((CMP_W'(j_cnt) + CMP_W'(1)) == end_ext);

  // ---------------------------------------------------------------------------
  // Frequency memory: append writes, registered read
  // ---------------------------------------------------------------------------
  assign wr_en   = in_accept & (in_op == OP_APPEND) &
                   (in_restart | (stored_count < CNT_W'(MAX_FREQS)));
  assign wr_addr = in_restart ? '0 : IDX_W'(stored_count);

  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = IDX_W'(in_first);
      S_LD_A:  rd_addr = IDX_W'(k_reg);
      S_OUT:   rd_addr = IDX_W'(j_cnt + SPAN_W'(1));
      default: rd_addr = IDX_W'(j_cnt);
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      freq_mem[wr_addr] <= in_freq;
    end
    mem_rdata <= freq_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
    end else if (wr_en) begin
      stored_count <= in_restart ? CNT_W'(1) : stored_count + CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared adder: operand selection per sequencer step
  // ---------------------------------------------------------------------------
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_LD_C: begin
        alu_x   = ALU_W'(a_val);
        alu_y   = ALU_W'(mem_rdata);
        alu_sub = 1'b1;
      end
      S_LD_2: begin
        // 2A - C as (A - C) + A; the memory already returns B here
        alu_x = amc;
        alu_y = ALU_W'(a_val);
      end
      S_DIFF: begin
        alu_x = (test == T_DBL_FIRST) ? a2mc : amc;
        alu_y = (test == T_DBL_SECOND) ? ALU_W'({b_val, 1'b0}) : ALU_W'(b_val);
      end
      S_CAND: begin
        alu_x   = d_val;
        alu_y   = (try_code == CODE_EXACT) ? '0 : ALU_W'(alias_spacing);
        alu_sub = (try_code == CODE_MINUS);
      end
      default: begin
        alu_x = '0;
      end
    endcase
  end

  assign alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + ALU_W'(alu_sub);

  // Strict window check on the candidate residual
  assign tol_s      = signed'(ALU_W'(match_tolerance));
  assign cand_match = (alu_sum < tol_s) & (alu_sum > -tol_s);
  assign test_done  = cand_match | (try_code == CODE_PLUS);
  assign hit_code   = cand_match ? try_code : CODE_NONE;
  assign hit_res    = cand_match ? alu_sum[RES_W-1:0] : '0;

  always_comb begin
    unique case (try_code)
      CODE_EXACT: try_code_next = CODE_MINUS;
      CODE_MINUS: try_code_next = CODE_PLUS;
      default:    try_code_next = CODE_PLUS;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: state register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && in_op == OP_SEARCH) begin
          state_next = in_bad ? S_OUT : S_LD_A;
        end
      end
      S_LD_A: state_next = S_LD_C;
      S_LD_C: state_next = S_LD_2;
      S_LD_2: state_next = S_DIFF;
      S_LD_B: state_next = S_DIFF;
      S_DIFF: state_next = S_CAND;
      S_CAND: begin
        if (test_done) begin
          state_next = (test == T_DBL_SECOND) ? S_OUT : S_DIFF;
        end
      end
      S_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = last_result ? S_IDLE : S_LD_B;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_accept && in_op == OP_SEARCH) begin
          k_reg    <= in_target;
          j_cnt    <= in_bad ? '0 : SPAN_W'(in_first);
          bad_flag <= in_bad;
          test     <= T_SUM;
          // a bad index result carries all-zero codes and residuals
          sum_code     <= CODE_NONE;
          dfirst_code  <= CODE_NONE;
          dsecond_code <= CODE_NONE;
          sum_res      <= '0;
          dfirst_res   <= '0;
          dsecond_res  <= '0;
        end
      end
      S_LD_A: a_val <= mem_rdata;
      S_LD_C: amc   <= alu_sum;
      S_LD_2: begin
        a2mc  <= alu_sum;
        b_val <= mem_rdata;
      end
      S_LD_B: b_val <= mem_rdata;
      S_DIFF: begin
        d_val    <= alu_sum;
        try_code <= CODE_EXACT;
      end
      S_CAND: begin
        if (test_done) begin
          // store the verdict for this sum and move to the next one
          unique case (test)
            T_SUM: begin
              sum_code <= hit_code;
              sum_res  <= hit_res;
              test     <= T_DBL_FIRST;
            end
            T_DBL_FIRST: begin
              dfirst_code <= hit_code;
              dfirst_res  <= hit_res;
              test        <= T_DBL_SECOND;
            end
            default: begin
              dsecond_code <= hit_code;
              dsecond_res  <= hit_res;
              test         <= T_SUM;
            end
          endcase
        end else begin
          try_code <= try_code_next;
        end
      end
      S_OUT: begin
        // advance to the next B once this beat is taken
        if (out_accept && !last_result) begin
          j_cnt <= j_cnt + SPAN_W'(1);
        end
      end
      default: begin
        test <= T_SUM;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result beat
  // ---------------------------------------------------------------------------
  assign m_tdata = {5'b0,
                    dsecond_res, dsecond_code,
                    dfirst_res, dfirst_code,
                    sum_res, sum_code,
                    j_cnt[FIELD_IDX_W-1:0]};
  assign m_tuser = bad_flag;
  assign m_tlast = last_result;

endmodule
